// ----- hw/rtl/ldf_pkg.sv -----
`default_nettype none

package ldf_pkg;

	// item kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_FLUSH = 2'd2;

	// serial frame codes
	localparam logic [7:0] SYNC_COMMAND    = 8'hF8;
	localparam logic [7:0] SYNC_DATA       = 8'hFA;
	localparam logic [7:0] ADDRESS_COMMAND = 8'h80;

	// pause marks
	localparam logic [1:0] PAUSE_NONE = 2'd0;
	localparam logic [1:0] PAUSE_CMD  = 2'd1;
	localparam logic [1:0] PAUSE_WORD = 2'd2;

	// word index width: up to sixteen words in a row, plus the end mark
	localparam int WORD_W = 5;

	// one byte handed to the framer, or a blank result when blank is set
	typedef struct packed {
		logic       blank;
		logic [7:0] sync;
		logic [7:0] data;
		logic [1:0] pause;
		logic       more;
		logic       last;
	} frame_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lcd_dirty_row_flush_framer.sv -----
`default_nettype none

// Dirty-row flush framer for a monochrome graphic display on a three-byte serial link.
// Requests arrive on s_axis; tuser carries the kind (write image byte, load dirty region,
// flush step). Results leave on m_axis, one serial byte each, tlast on the final one.
// A write, a load, an unused kind or a flush of a clean region gives one blank result
// (byte_valid 0) via ST_DONE and the framer; the next request is taken after its handoff.
// A flush step with a dirty region gives 6 + 6*W results, W being the number of 16-bit
// words covering the dirty columns (54 for a full 128-pixel row): two address commands
// then the data bytes, each as a sync/high-nibble/low-nibble frame. The first result
// leaves via ST_CMD0 and the framer, and the rest follow back to back while m_axis is
// ready, the rate set by the framer's three results per byte; each store read fits inside
// the frame before. s_axis_tready rises again once the last byte of a flush is handed to
// the framer, while its final frame drains.
// After reset the frame store is swept to zero, one byte a cycle, all (DISPLAY_WIDTH/8) *
// DISPLAY_HEIGHT bytes (1024 by default); no request is taken meanwhile.
// A stall on m_axis holds the framer and, behind it, the sequencer; nothing is dropped.

module lcd_dirty_row_flush_framer
	import ldf_pkg::*;
#(
	parameter int DISPLAY_WIDTH  = 128,
	parameter int DISPLAY_HEIGHT = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// pixel_row[5:0], byte_column[9:6], pixel_byte[17:10], region_start_row[24:18],
	// region_end_row[31:25], region_start_col[39:32], region_end_col[47:40]
	input  wire  [47:0] s_axis_tdata,
	input  wire  [1:0]  s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// serial_byte[7:0], byte_valid[8], pause_after[10:9], more_pending[11]
	output logic [15:0] m_axis_tdata,
	output logic        m_axis_tlast    // last
);

	localparam int ROW_BYTES   = DISPLAY_WIDTH / 8;
	localparam int STORE_BYTES = ROW_BYTES * DISPLAY_HEIGHT;
	localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int ROW_W       = $clog2(DISPLAY_HEIGHT + 1);
	localparam int COL_W       = $clog2(DISPLAY_WIDTH + 1);

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CMD0 = 3'd1;
	localparam logic [2:0] ST_CMD1 = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_DAT  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	// request fields
	logic [5:0] pixel_row;
	logic [3:0] byte_column;
	logic [7:0] pixel_byte;
	logic [6:0] region_start_row;
	logic [6:0] region_end_row;
	logic [7:0] region_start_col;
	logic [7:0] region_end_col;

	assign pixel_row        = s_axis_tdata[5:0];
	assign byte_column      = s_axis_tdata[9:6];
	assign pixel_byte       = s_axis_tdata[17:10];
	assign region_start_row = s_axis_tdata[24:18];
	assign region_end_row   = s_axis_tdata[31:25];
	assign region_start_col = s_axis_tdata[39:32];
	assign region_end_col   = s_axis_tdata[47:40];

	logic [2:0]        state_q;
	logic [ROW_W-1:0]  first_row_q;
	logic [ROW_W-1:0]  end_row_q;
	logic [COL_W-1:0]  first_col_q;
	logic [COL_W-1:0]  end_col_q;
	logic [ROW_W-1:0]  next_row_q;
	logic [ROW_W-1:0]  row_q;
	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] end_word_q;
	logic              sel_q;
	logic              more_q;
	logic              rd_zero_q;

	logic              accept;
	logic              dirty;
	logic [ROW_W-1:0]  pick_row;
	logic [ROW_W-1:0]  first_after;
	logic              flush_more;
	logic [COL_W:0]    end_col_up;
	logic [4:0]        rd_col;
	logic [6:0]        row_ext;
	logic              last_byte;

	logic              st_busy;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;

	logic              req_load;
	logic              req_ready;
	frame_req_t        req;

	assign s_axis_tready = (state_q == ST_IDLE) && !st_busy;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign dirty = (end_col_q > first_col_q) && (end_row_q > first_row_q);

	// restart at the first dirty row when the pointer has left the region
	always_comb begin
		if (next_row_q < first_row_q || next_row_q >= end_row_q) begin
			pick_row = first_row_q;
		end else begin
			pick_row = next_row_q;
		end
		first_after = (pick_row == first_row_q) ? first_row_q + 1'b1 : first_row_q;
		flush_more  = first_after != end_row_q;
		end_col_up  = {1'b0, end_col_q} + (COL_W + 1)'(15);
	end

	// drop writes that fall outside the display
	assign wr_en   = accept && s_axis_tuser == KIND_WRITE
	                 && int'(pixel_row) < DISPLAY_HEIGHT && int'(byte_column) < ROW_BYTES;
	assign wr_addr = ADDR_W'(int'(pixel_row) * ROW_BYTES + int'(byte_column));

	// two bytes per word: byte column is word * 2 + sel
	assign rd_col  = {word_q[3:0], sel_q};
	assign rd_en   = state_q == ST_RD;
	assign rd_addr = ADDR_W'(int'(row_q) * ROW_BYTES + int'(rd_col));

	assign row_ext   = 7'(row_q);
	assign last_byte = sel_q && ((word_q + 1'b1) == end_word_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			first_row_q <= ROW_W'(DISPLAY_HEIGHT);
			end_row_q   <= '0;
			first_col_q <= COL_W'(DISPLAY_WIDTH);
			end_col_q   <= '0;
			next_row_q  <= '0;
			word_q      <= '0;
			end_word_q  <= '0;
			sel_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_axis_tuser)
							KIND_LOAD: begin
								// saturate the bounds to the display
								first_row_q <= (region_start_row > 7'(DISPLAY_HEIGHT))
								               ? ROW_W'(DISPLAY_HEIGHT) : ROW_W'(region_start_row);
								end_row_q   <= (region_end_row > 7'(DISPLAY_HEIGHT))
								               ? ROW_W'(DISPLAY_HEIGHT) : ROW_W'(region_end_row);
								first_col_q <= ({1'b0, region_start_col} > 9'(DISPLAY_WIDTH))
								               ? COL_W'(DISPLAY_WIDTH) : COL_W'(region_start_col);
								end_col_q   <= ({1'b0, region_end_col} > 9'(DISPLAY_WIDTH))
								               ? COL_W'(DISPLAY_WIDTH) : COL_W'(region_end_col);
								state_q     <= ST_DONE;
							end
							KIND_FLUSH: begin
								if (dirty) begin
									word_q     <= WORD_W'(first_col_q >> 4);
									end_word_q <= WORD_W'(end_col_up >> 4);
									sel_q      <= 1'b0;
									if (flush_more) begin
										first_row_q <= first_after;
										next_row_q  <= pick_row + 1'b1;
									end else begin
										// region fully sent: back to clean
										first_row_q <= ROW_W'(DISPLAY_HEIGHT);
										end_row_q   <= '0;
										first_col_q <= COL_W'(DISPLAY_WIDTH);
										end_col_q   <= '0;
										next_row_q  <= '0;
									end
									state_q <= ST_CMD0;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_CMD0: begin
					if (req_ready) begin
						state_q <= ST_CMD1;
					end
				end
				ST_CMD1: begin
					if (req_ready) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_DAT;
				ST_DAT: begin
					if (req_ready) begin
						sel_q <= !sel_q;
						if (sel_q) begin
							word_q <= word_q + 1'b1;
						end
						state_q <= last_byte ? ST_IDLE : ST_RD;
					end
				end
				ST_DONE: begin
					if (req_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// flush payload: sent row, pending flag, bytes beyond the row read as zero
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q  <= pick_row;
			more_q <= flush_more;
		end
		if (rd_en) begin
			rd_zero_q <= int'(rd_col) >= ROW_BYTES;
		end
	end

	always_comb begin
		req_load   = 1'b0;
		req.blank  = 1'b0;
		req.sync   = SYNC_COMMAND;
		req.data   = ADDRESS_COMMAND | {3'b000, row_ext[4:0]};
		req.pause  = PAUSE_NONE;
		req.more   = more_q;
		req.last   = 1'b0;
		case (state_q)
			ST_CMD0: begin
				req_load = 1'b1;
			end
			ST_CMD1: begin
				req_load  = 1'b1;
				req.data  = ADDRESS_COMMAND | {4'h0, word_q[3:0]} | {4'h0, row_ext[5], 3'b000};
				req.pause = PAUSE_CMD;
			end
			ST_DAT: begin
				req_load  = 1'b1;
				req.sync  = SYNC_DATA;
				req.data  = rd_zero_q ? 8'h00 : rd_data;
				req.pause = sel_q ? PAUSE_WORD : PAUSE_NONE;
				req.last  = last_byte;
			end
			ST_DONE: begin
				req_load  = 1'b1;
				req.blank = 1'b1;
				req.data  = 8'h00;
				req.more  = dirty;
				req.last  = 1'b1;
			end
			default: req_load = 1'b0;
		endcase
	end

	ldf_store #(
		.DEPTH  (STORE_BYTES),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (pixel_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.busy    (st_busy)
	);

	ldf_framer u_framer (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_load      (req_load),
		.req           (req),
		.req_ready     (req_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/ldf_store.sv -----
`default_nettype none

module ldf_store
	import ldf_pkg::*;
#(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                wr_en,
	input  wire [ADDR_W-1:0]   wr_addr,
	input  wire [7:0]          wr_data,
	input  wire                rd_en,
	input  wire [ADDR_W-1:0]   rd_addr,
	output logic [7:0]         rd_data,
	output logic               busy
);

	logic [7:0]        mem [DEPTH];
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_busy_q;
	logic              mem_wen;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;

	assign busy = clr_busy_q;

	// sweep every entry to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_comb begin
		mem_wen   = clr_busy_q | wr_en;
		mem_waddr = clr_busy_q ? clr_addr_q : wr_addr;
		mem_wdata = clr_busy_q ? 8'h00 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_wen) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/ldf_framer.sv -----
`default_nettype none

module ldf_framer
	import ldf_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         req_load,
	input  frame_req_t  req,
	output logic        req_ready,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,  // serial_byte[7:0], byte_valid, pause_after[1:0], more_pending
	output logic        m_axis_tlast
);

	frame_req_t req_q;
	logic       busy_q;
	logic [1:0] phase_q;
	logic       finishing;
	logic [7:0] serial;
	logic       valid_bit;
	logic [1:0] pause;

	assign finishing = req_q.blank || (phase_q == 2'd2);
	assign req_ready = !busy_q || (m_axis_tready && finishing);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 2'd0;
		end else if (req_load && req_ready) begin
			busy_q  <= 1'b1;
			phase_q <= 2'd0;
		end else if (busy_q && m_axis_tready) begin
			if (finishing) begin
				busy_q <= 1'b0;
			end
			phase_q <= phase_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_load && req_ready) begin
			req_q <= req;
		end
	end

	// sync, then high nibble, then low nibble moved up
	always_comb begin
		case (phase_q)
			2'd0:    serial = req_q.sync;
			2'd1:    serial = {req_q.data[7:4], 4'h0};
			default: serial = {req_q.data[3:0], 4'h0};
		endcase
		if (req_q.blank) begin
			serial = 8'h00;
		end
		valid_bit = !req_q.blank;
		pause     = (!req_q.blank && phase_q == 2'd2) ? req_q.pause : PAUSE_NONE;
	end

	assign m_axis_tvalid = busy_q;
	assign m_axis_tdata  = {4'h0, req_q.more, pause, valid_bit, serial};
	assign m_axis_tlast  = req_q.last && finishing;

endmodule

`default_nettype wire
